FILE: hw/rtl/fud_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Form body decoder package
// Shared types, character codes and the hex digit decode used by the
// form-urlencoded stream decoder.
// ----------------------------------------------------------------------------
package fud_pkg;

	localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
	localparam logic [7:0] CHAR_AMP     = 8'h26;
	localparam logic [7:0] CHAR_PERCENT = 8'h25;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;

	localparam logic REPLACE_PLUS_RESET = 1'b1;

	typedef enum logic [2:0] {
		PH_PAIR_START  = 3'd0,
		PH_KEY         = 3'd1,
		PH_VALUE_START = 3'd2,
		PH_VALUE       = 3'd3,
		PH_STOPPED     = 3'd4
	} parse_phase_t;

	typedef enum logic [1:0] {
		ESC_NONE   = 2'd0,
		ESC_FIRST  = 2'd1,
		ESC_SECOND = 2'd2
	} esc_phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       in_value;
		logic       pair_end;
		logic       pair_dropped;
		logic       format_stop;
		logic       body_done;
	} out_item_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		d.ok    = 1'b1;
		d.value = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			d.value = 4'(c - 8'h30);
		end else if (c inside {[8'h61:8'h66]}) begin
			d.value = 4'(c - 8'h57);
		end else if (c inside {[8'h41:8'h46]}) begin
			d.value = 4'(c - 8'h37);
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/form_urlencoded_stream_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Form-urlencoded stream decoder
// Splits a form body into key and value segments, percent-decodes them and
// streams out tagged bytes with pair and error marks.
// ----------------------------------------------------------------------------
// Each result is registered in the output entry, or in the skid entry while the output entry is held.
// Throughput: one byte per cycle, set by the combinational parse and decode
// step; a two-entry output register and skid stage keep input flowing while
// a result waits. Input stalls only when both entries are full.
// Reset clears the parse state, the output entries and sets replace_plus to 1.
module form_urlencoded_stream_decoder_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire fud_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output fud_pkg::out_item_t     out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_data
);
	import fud_pkg::*;

	logic         replace_plus_q;
	parse_phase_t phase_q;
	esc_phase_t   esc_q;
	logic [3:0]   hn_q;
	logic         bad_q;

	logic         skid_valid_q;
	out_item_t    skid_q;
	logic         out_valid_q;
	out_item_t    out_q;

	logic         accept;
	logic         out_take;

	esc_phase_t   seg_esc;
	logic [3:0]   seg_hn;
	logic         seg_bad;
	esc_phase_t   dec_esc;
	logic [3:0]   dec_hn;
	logic         dec_bad;
	logic         dec_valid;
	logic [7:0]   dec_byte;
	hex_digit_t   hex;

	parse_phase_t phase_d;
	esc_phase_t   esc_d;
	logic [3:0]   hn_d;
	logic         bad_d;
	out_item_t    res;
	logic         has_result;

	logic [7:0]   c;
	logic         last;

	assign c         = in_data.in_byte;
	assign last      = in_data.in_last;
	assign in_stall  = skid_valid_q;
	assign accept    = in_valid && !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_take  = out_valid_q && !out_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		if (phase_q == PH_PAIR_START) begin
			seg_esc = ESC_NONE;
			seg_hn  = 4'd0;
			seg_bad = 1'b0;
		end else begin
			seg_esc = esc_q;
			seg_hn  = hn_q;
			seg_bad = bad_q;
		end
	end

	always_comb begin
		hex       = hex_decode(c);
		dec_esc   = seg_esc;
		dec_hn    = seg_hn;
		dec_bad   = seg_bad;
		dec_valid = 1'b0;
		dec_byte  = c;
		if (!seg_bad) begin
			case (seg_esc)
				ESC_FIRST, ESC_SECOND: begin
					if (!hex.ok) begin
						dec_bad = 1'b1;
						dec_esc = ESC_NONE;
					end else if (seg_esc == ESC_FIRST) begin
						dec_hn  = hex.value;
						dec_esc = ESC_SECOND;
					end else begin
						dec_byte  = {seg_hn, hex.value};
						dec_esc   = ESC_NONE;
						dec_valid = 1'b1;
					end
				end
				default: begin
					dec_esc = ESC_NONE;
					if (c == CHAR_PERCENT) begin
						dec_esc = ESC_FIRST;
					end else if (c == CHAR_PLUS && replace_plus_q) begin
						dec_byte  = CHAR_SPACE;
						dec_valid = 1'b1;
					end else begin
						dec_valid = 1'b1;
					end
				end
			endcase
		end
	end

	always_comb begin
		phase_d = phase_q;
		esc_d   = esc_q;
		hn_d    = hn_q;
		bad_d   = bad_q;
		res     = '0;
		case (phase_q)
			PH_PAIR_START: begin
				if (c == CHAR_EQUALS) begin
					res.format_stop = 1'b1;
					phase_d         = PH_STOPPED;
				end else begin
					esc_d            = dec_esc;
					hn_d             = dec_hn;
					bad_d            = dec_bad;
					res.byte_valid   = dec_valid;
					phase_d          = PH_KEY;
					res.pair_dropped = last;
					res.format_stop  = last;
				end
			end
			PH_KEY: begin
				if (c == CHAR_EQUALS) begin
					esc_d           = ESC_NONE;
					hn_d            = 4'd0;
					bad_d           = 1'b0;
					phase_d         = PH_VALUE_START;
					res.format_stop = last;
				end else begin
					esc_d            = dec_esc;
					hn_d             = dec_hn;
					bad_d            = dec_bad;
					res.byte_valid   = dec_valid;
					res.pair_dropped = last;
					res.format_stop  = last;
				end
			end
			PH_VALUE_START: begin
				if (c == CHAR_AMP) begin
					res.format_stop = 1'b1;
					phase_d         = PH_STOPPED;
				end else begin
					esc_d          = dec_esc;
					hn_d           = dec_hn;
					bad_d          = dec_bad;
					res.byte_valid = dec_valid;
					res.in_value   = dec_valid;
					phase_d        = PH_VALUE;
					res.pair_end   = last;
				end
			end
			PH_VALUE: begin
				if (c == CHAR_AMP) begin
					res.pair_end = 1'b1;
					phase_d      = PH_PAIR_START;
				end else begin
					esc_d          = dec_esc;
					hn_d           = dec_hn;
					bad_d          = dec_bad;
					res.byte_valid = dec_valid;
					res.in_value   = dec_valid;
					res.pair_end   = last;
				end
			end
			default: begin
			end
		endcase
		if (last) begin
			phase_d = PH_PAIR_START;
			esc_d   = ESC_NONE;
			hn_d    = 4'd0;
			bad_d   = 1'b0;
		end
		res.out_byte  = res.byte_valid ? dec_byte : 8'd0;
		res.body_done = last;
		has_result    = res.byte_valid || res.pair_end || res.pair_dropped
			|| res.format_stop || res.body_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replace_plus_q <= REPLACE_PLUS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			replace_plus_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PAIR_START;
			esc_q   <= ESC_NONE;
			hn_q    <= 4'd0;
			bad_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			esc_q   <= esc_d;
			hn_q    <= hn_d;
			bad_q   <= bad_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept && has_result) begin
			if (out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (accept && has_result) begin
			if (out_valid_q && !out_take) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output entry");

	a_result_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.byte_valid || out_q.pair_end || out_q.pair_dropped
			|| out_q.format_stop || out_q.body_done))
		else $error("result transfer carries no flag");

	a_idle_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.byte_valid) |-> (out_q.out_byte == 8'd0 && !out_q.in_value))
		else $error("byte fields set without a decoded byte");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.in_last) |=>
			(phase_q == PH_PAIR_START && esc_q == ESC_NONE && !bad_q && hn_q == 4'd0))
		else $error("parse state not cleared after final byte");

	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q == PH_STOPPED && !in_data.in_last) |=> (phase_q == PH_STOPPED))
		else $error("parsing resumed after a format stop");

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Form-urlencoded stream decoder testbench
// Feeds form bodies one byte per transfer: a short directed set of edge
// cases, then random bodies that are mostly well formed with random content,
// plus broken and noisy ones. A scoreboard predicts every decoded result and
// compares it field by field against the output, with random idling on both
// sides, a long receiver hold-off and plus replacement toggled between phases.
// ----------------------------------------------------------------------------
module testbench;
	import fud_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int CYCLE_LIMIT   = 400000;

	class form_scoreboard;
		out_item_t    expected_results[$];
		logic         replace_plus;
		parse_phase_t phase;
		esc_phase_t   esc;
		logic [3:0]   nibble;
		logic         seg_bad;
		int           errors;
		int           checked;

		function new();
			replace_plus = REPLACE_PLUS_RESET;
			phase        = PH_PAIR_START;
			errors       = 0;
			checked      = 0;
			clear_segment();
		endfunction

		function void clear_segment();
			esc     = ESC_NONE;
			nibble  = 4'd0;
			seg_bad = 1'b0;
		endfunction

		function int hex_value(logic [7:0] c);
			if (c >= "0" && c <= "9") return int'(c) - "0";
			if (c >= "a" && c <= "f") return int'(c) - "a" + 10;
			if (c >= "A" && c <= "F") return int'(c) - "A" + 10;
			return -1;
		endfunction

		function logic decode(input logic [7:0] c, output logic [7:0] b);
			int d;
			b = 8'h00;
			if (seg_bad) return 1'b0;
			if (esc == ESC_FIRST || esc == ESC_SECOND) begin
				d = hex_value(c);
				if (d < 0) begin
					seg_bad = 1'b1;
					esc     = ESC_NONE;
					return 1'b0;
				end
				if (esc == ESC_FIRST) begin
					nibble = d[3:0];
					esc    = ESC_SECOND;
					return 1'b0;
				end
				b   = {nibble, d[3:0]};
				esc = ESC_NONE;
				return 1'b1;
			end
			esc = ESC_NONE;
			if (c == CHAR_PERCENT) begin
				esc = ESC_FIRST;
				return 1'b0;
			end
			if (c == CHAR_PLUS && replace_plus) begin
				b = CHAR_SPACE;
				return 1'b1;
			end
			b = c;
			return 1'b1;
		endfunction

		function void note_input(in_item_t it);
			out_item_t  r;
			logic [7:0] c;
			logic [7:0] b;
			logic       last;
			r    = '0;
			b    = 8'h00;
			c    = it.in_byte;
			last = it.in_last;
			case (phase)
				PH_PAIR_START: begin
					if (c == CHAR_EQUALS) begin
						r.format_stop = 1'b1;
						phase         = PH_STOPPED;
					end else begin
						clear_segment();
						r.byte_valid = decode(c, b);
						phase        = PH_KEY;
						if (last) begin
							r.pair_dropped = 1'b1;
							r.format_stop  = 1'b1;
						end
					end
				end
				PH_KEY: begin
					if (c == CHAR_EQUALS) begin
						clear_segment();
						phase = PH_VALUE_START;
						if (last) r.format_stop = 1'b1;
					end else begin
						r.byte_valid = decode(c, b);
						if (last) begin
							r.pair_dropped = 1'b1;
							r.format_stop  = 1'b1;
						end
					end
				end
				PH_VALUE_START: begin
					if (c == CHAR_AMP) begin
						r.format_stop = 1'b1;
						phase         = PH_STOPPED;
					end else begin
						r.byte_valid = decode(c, b);
						r.in_value   = r.byte_valid;
						phase        = PH_VALUE;
						if (last) r.pair_end = 1'b1;
					end
				end
				PH_VALUE: begin
					if (c == CHAR_AMP) begin
						r.pair_end = 1'b1;
						phase      = PH_PAIR_START;
					end else begin
						r.byte_valid = decode(c, b);
						r.in_value   = r.byte_valid;
						if (last) r.pair_end = 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (last) begin
				phase = PH_PAIR_START;
				clear_segment();
			end
			r.out_byte  = r.byte_valid ? b : 8'h00;
			r.body_done = last;
			if (r.byte_valid || r.pair_end || r.pair_dropped || r.format_stop || last)
				expected_results.push_back(r);
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40) $display("ERROR: %s", msg);
		endtask

		task compare_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("result %0d %s: got %h, expected %h", checked, name, got, want));
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (expected_results.size() == 0) begin
				report($sformatf("result with nothing expected: %h", got));
				return;
			end
			want = expected_results.pop_front();
			compare_field("out_byte", got.out_byte, want.out_byte);
			compare_field("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
			compare_field("in_value", 8'(got.in_value), 8'(want.in_value));
			compare_field("pair_end", 8'(got.pair_end), 8'(want.pair_end));
			compare_field("pair_dropped", 8'(got.pair_dropped), 8'(want.pair_dropped));
			compare_field("format_stop", 8'(got.format_stop), 8'(want.format_stop));
			compare_field("body_done", 8'(got.body_done), 8'(want.body_done));
			checked++;
		endtask
	endclass

	logic      clk;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_data = 1'b0;

	form_scoreboard sb = new();
	in_item_t       body_q[$];
	int             items_sent = 0;
	int             cycles = 0;
	logic           quiet = 1'b0;
	logic           tx_gaps = 1'b0;
	logic           hold_req = 1'b0;

	form_urlencoded_stream_decoder_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	initial begin
		int   mode_left;
		int   burst;
		logic rx_busy;
		mode_left = 0;
		rx_busy   = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!quiet && arst_n) begin
				if (mode_left == 0) begin
					rx_busy   = ($urandom_range(0, 2) != 0);
					mode_left = 64;
				end
				mode_left--;
				if (rx_busy && $urandom_range(0, 7) == 0) begin
					burst = $urandom_range(1, 19);
					out_stall <= 1'b1;
					repeat (burst) @(posedge clk);
					out_stall <= 1'b0;
				end
			end
		end
	end

	function automatic void push_byte(ref in_item_t q[$], input logic [7:0] b);
		in_item_t it;
		it.in_byte = b;
		it.in_last = 1'b0;
		q.push_back(it);
	endfunction

	function automatic void add_text(ref in_item_t q[$], input string s);
		for (int i = 0; i < s.len(); i++) push_byte(q, s[i]);
		q[q.size() - 1].in_last = 1'b1;
	endfunction

	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) return 8'("0" + v);
		return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
	endfunction

	function automatic logic [7:0] plain_char(input logic is_key);
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (c == CHAR_EQUALS || c == CHAR_PERCENT || (!is_key && c == CHAR_AMP));
		return c;
	endfunction

	function automatic logic [7:0] nonhex_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (sb.hex_value(c) >= 0 || c == CHAR_EQUALS || c == CHAR_AMP);
		return c;
	endfunction

	function automatic logic [7:0] noise_char();
		case ($urandom_range(0, 4))
			0: return CHAR_EQUALS;
			1: return CHAR_AMP;
			2: return CHAR_PERCENT;
			3: return hex_char();
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void gen_segment(ref in_item_t q[$], input logic is_key);
		int units;
		units = $urandom_range(1, 5);
		for (int i = 0; i < units; i++) begin
			case ($urandom_range(0, 9))
				6: push_byte(q, CHAR_PLUS);
				7, 8: begin
					push_byte(q, CHAR_PERCENT);
					push_byte(q, hex_char());
					push_byte(q, hex_char());
				end
				9: begin
					push_byte(q, CHAR_PERCENT);
					case ($urandom_range(0, 2))
						0: push_byte(q, nonhex_char());
						1: push_byte(q, hex_char());
						default: begin
						end
					endcase
				end
				default: push_byte(q, plain_char(is_key));
			endcase
		end
	endfunction

	function automatic void gen_pairs(ref in_item_t q[$], input int count);
		for (int p = 0; p < count; p++) begin
			if (p > 0) push_byte(q, CHAR_AMP);
			gen_segment(q, 1'b1);
			push_byte(q, CHAR_EQUALS);
			gen_segment(q, 1'b0);
		end
	endfunction

	function automatic void gen_body(ref in_item_t q[$]);
		int kind;
		int prefix;
		int n;
		kind = $urandom_range(0, 9);
		if (kind <= 7) begin
			gen_pairs(q, $urandom_range(1, 3));
			if ($urandom_range(0, 3) == 0) push_byte(q, CHAR_AMP);
		end else if (kind == 8) begin
			prefix = $urandom_range(0, 2);
			gen_pairs(q, prefix);
			if (prefix > 0) push_byte(q, CHAR_AMP);
			case ($urandom_range(0, 3))
				0: push_byte(q, CHAR_EQUALS);
				1: begin
					gen_segment(q, 1'b1);
					push_byte(q, CHAR_EQUALS);
					push_byte(q, CHAR_AMP);
				end
				2: gen_segment(q, 1'b1);
				default: begin
					gen_segment(q, 1'b1);
					push_byte(q, CHAR_EQUALS);
				end
			endcase
			n = $urandom_range(0, 4);
			for (int i = 0; i < n; i++) push_byte(q, noise_char());
		end else begin
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++) begin
				push_byte(q, noise_char());
				if ($urandom_range(0, 5) == 0) q[q.size() - 1].in_last = 1'b1;
			end
		end
		q[q.size() - 1].in_last = 1'b1;
	endfunction

	task automatic drive_item(input in_item_t it);
		int gap;
		gap = 0;
		if (!quiet && tx_gaps && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 19);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
		items_sent++;
	endtask

	task automatic send_queue();
		foreach (body_q[i]) drive_item(body_q[i]);
		body_q.delete();
	endtask

	task automatic send_stream(input int target);
		while (items_sent < target) begin
			tx_gaps = ($urandom_range(0, 3) != 0);
			gen_body(body_q);
			send_queue();
		end
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_replace_plus(input logic v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.replace_plus = v;
	endtask

	task automatic send_directed();
		push_byte(body_q, 8'h00);
		push_byte(body_q, CHAR_EQUALS);
		push_byte(body_q, 8'hFF);
		body_q[body_q.size() - 1].in_last = 1'b1;
		add_text(body_q, "=x");
		add_text(body_q, "k=&z");
		add_text(body_q, "k=");
		add_text(body_q, "+");
		add_text(body_q, "%41&+=%fF%g+&");
		add_text(body_q, "a=%4");
		tx_gaps = 1'b1;
		send_queue();
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		wait_drained();
		write_replace_plus(1'b0);
		send_stream(480);
		wait_drained();
		write_replace_plus(1'b1);
		hold_req = 1'b1;
		send_stream(950);
		wait_drained();
		write_replace_plus(1'b0);
		send_stream(1300);
		wait_drained();
		write_replace_plus(1'b1);
		quiet = 1'b1;
		send_stream(1750);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: form_urlencoded_stream_decoder_top.f
hw/rtl/fud_pkg.sv
hw/rtl/form_urlencoded_stream_decoder_top.sv
tb/sv/testbench.sv
